>>> hdl/mips_subset_instruction_core_assert.svh
// Assertion macros shared by the core's modules.
`ifndef MIPS_SUBSET_INSTRUCTION_CORE_ASSERT_SVH
`define MIPS_SUBSET_INSTRUCTION_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MSIC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MSIC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hdl/msic_pkg.sv
// Shared types, constants and helpers of the instruction core.
package msic_pkg;

   localparam int DATA_WORDS = 1024;
   localparam int DADDR_W    = $clog2(DATA_WORDS);
   localparam logic [31:0] DATA_BYTES = 32'(DATA_WORDS * 4);

   localparam logic [31:0] START_PC_RESET  = 32'h0040_0000;
   localparam logic [31:0] DATA_BASE_RESET = 32'h1000_0000;
   localparam logic [31:0] GP_RESET        = 32'h1000_8000;
   localparam logic [31:0] SP_BASE         = 32'h1000_0000;
   localparam logic [31:0] SP_RESET        = SP_BASE + DATA_BYTES;

   localparam logic [4:0] ZERO_REG_IDX = 5'd0;
   localparam logic [4:0] REG_GP       = 5'd28;
   localparam logic [4:0] REG_SP       = 5'd29;
   localparam logic [4:0] REG_RA       = 5'd31;

   // csr indexes
   localparam logic CSR_START_PC  = 1'b0;
   localparam logic CSR_DATA_BASE = 1'b1;

   // opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_ANDI    = 6'h0c;
   localparam logic [5:0] OP_LUI     = 6'h0f;
   localparam logic [5:0] OP_TRAP    = 6'h1a;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_SW      = 6'h2b;

   // funct codes
   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRA  = 6'h03;
   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_MFHI = 6'h10;
   localparam logic [5:0] FN_MFLO = 6'h12;
   localparam logic [5:0] FN_MULT = 6'h18;
   localparam logic [5:0] FN_DIV  = 6'h1a;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUBU = 6'h23;
   localparam logic [5:0] FN_SLT  = 6'h2a;

   // trap selectors
   localparam logic [3:0] TRAP_NEWLINE = 4'h0;
   localparam logic [3:0] TRAP_PRINT   = 4'h1;
   localparam logic [3:0] TRAP_READ    = 4'h5;
   localparam logic [3:0] TRAP_HALT    = 4'ha;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_INSN  = 2'd1;
   localparam logic [1:0] ERR_TRAP  = 2'd2;
   localparam logic [1:0] ERR_DADDR = 2'd3;

   localparam logic [1:0] PK_NONE    = 2'd0;
   localparam logic [1:0] PK_NEWLINE = 2'd1;
   localparam logic [1:0] PK_INT     = 2'd2;
   localparam logic [1:0] PK_PROMPT  = 2'd3;

   typedef struct packed {
      logic [31:0] instruction;
      logic [31:0] console_value;
   } req_type;

   typedef struct packed {
      logic [31:0]        next_pc;
      logic               reg_write;
      logic [4:0]         reg_index;
      logic [31:0]        reg_value;
      logic               halted;
      logic [1:0]         error_code;
      logic [1:0]         print_kind;
      logic signed [31:0] print_value;
   } rsp_type;

   typedef struct packed {
      logic latch;
      logic clear_step;
      logic exec;
      logic div_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic div_go;
      logic div_last;
      logic out_free;
   } sts_type;

   function automatic logic [31:0] rf_reset_value(input logic [4:0] idx);
      logic [31:0] v;
      v = 32'd0;
      if (idx == REG_GP) v = GP_RESET;
      if (idx == REG_SP) v = SP_RESET;
      return v;
   endfunction

endpackage

>>> hdl/mips_subset_instruction_core.sv
// Top level of the MIPS integer subset instruction core.
// One request carries an instruction word (and the console value for the
// read-integer trap); one response reports the next PC, the register write,
// console output and halt/error status. A request is executed, then
// committed into the output register, where its response becomes valid;
// div with a nonzero divisor adds a pass through the one-bit-per-cycle
// restoring divider between the two. A new request is taken only once the
// previous one has committed (accept, execute, commit). Register file
// reads come from a registered RAM, so execution starts the cycle after
// acceptance. After reset a clearing pass zeroes the data memory, one word
// a cycle, all DATA_WORDS (1024) words, before the first request is taken;
// csr writes are taken during it. A finished response sits in an output
// register, so the next request may be accepted while it waits; that
// request's commit then waits for as long as the held response is stalled.
// csr index 0 (start_pc) has no effect once out of reset: the PC reset
// value is fixed. csr index 1 sets data_base.
module mips_subset_instruction_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  msic_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output msic_pkg::rsp_type  rsp_data,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata
);
   import msic_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencing: clear, idle, execute, divide, commit
   msic_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_ready(req_ready), .sts(sts), .cmd(cmd));

   // architectural state, memories and execution
   msic_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_data(rsp_data), .csr_write(csr_write), .csr_index(csr_index),
      .csr_wdata(csr_wdata));
endmodule

>>> hdl/msic_ram.sv
// Generic single-write, single-read RAM with registered read data.
module msic_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> hdl/msic_ctrl.sv
// Controller state machine of the instruction core.
`include "mips_subset_instruction_core_assert.svh"
module msic_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  msic_pkg::sts_type sts,
   output msic_pkg::cmd_type cmd
);
   import msic_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_EXEC   = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (sts.clear_last) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_EXEC;
         ST_EXEC:   state_in = sts.div_go ? ST_DIV : ST_FINISH;
         ST_DIV:    if (sts.div_last) state_in = ST_FINISH;
         ST_FINISH: if (sts.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign cmd.latch      = (state_ff == ST_IDLE) && req_valid;
   assign cmd.clear_step = (state_ff == ST_CLEAR);
   assign cmd.exec       = (state_ff == ST_EXEC);
   assign cmd.div_step   = (state_ff == ST_DIV);
   assign cmd.commit     = (state_ff == ST_FINISH) && sts.out_free;

   `MSIC_ASSERT_NOW(a_exec_after_accept, clock, reset,
      state_ff == ST_EXEC, $past(state_ff) == ST_IDLE)
   `MSIC_ASSERT_NEXT(a_div_ends, clock, reset,
      state_ff == ST_DIV && sts.div_last, state_ff == ST_FINISH)
endmodule

>>> hdl/msic_datapath.sv
// Datapath of the instruction core: registers, memories, ALU, divider.
`include "mips_subset_instruction_core_assert.svh"
module msic_datapath (
   input  logic              clock,
   input  logic              reset,
   input  msic_pkg::cmd_type  cmd,
   output msic_pkg::sts_type  sts,
   input  msic_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output msic_pkg::rsp_type  rsp_data,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata
);
   import msic_pkg::*;

   logic [31:0] ins_ff, cval_ff;
   logic [31:0] pc_ff, hi_ff, lo_ff, data_base_ff;
   logic        stopped_ff;
   logic [31:0] rf_valid_ff;
   rsp_type     res_ff, res_in, rsp_ff, fin;
   logic        load_ff, mult_ff, div_ff;
   logic [63:0] prod_ff;
   logic signed [63:0] prod_in;
   logic [31:0] quo_ff, rem_ff, mb_ff;
   logic        qneg_ff, rneg_ff;
   logic [4:0]  dcnt_ff;
   logic [DADDR_W-1:0] clr_ff;
   logic        rsp_valid_ff;

   logic [31:0] rfa_q, rfb_q, vs, vt, dram_q;
   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd, sh;
   logic [31:0] uimm, simm, pc4, daddr, doff;
   logic        dok, is_mult, is_div, is_load, is_store;
   logic        wr;
   logic [4:0]  dest;
   logic [31:0] val;
   logic        dram_we;
   logic [DADDR_W-1:0] dram_waddr;
   logic [31:0] dram_wdata;
   logic [32:0] dtmp;
   logic        dge;

   assign op   = ins_ff[31:26];
   assign rs   = ins_ff[25:21];
   assign rt   = ins_ff[20:16];
   assign rd   = ins_ff[15:11];
   assign sh   = ins_ff[10:6];
   assign fn   = ins_ff[5:0];
   assign uimm = {16'd0, ins_ff[15:0]};
   assign simm = {{16{ins_ff[15]}}, ins_ff[15:0]};
   assign pc4  = pc_ff + 32'd4;

   // register file: two copies give two read ports
   msic_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
      .clock(clock), .we(cmd.commit && fin.reg_write), .waddr(fin.reg_index),
      .wdata(fin.reg_value), .re(cmd.latch), .raddr(req_data.instruction[25:21]),
      .rdata(rfa_q));
   msic_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
      .clock(clock), .we(cmd.commit && fin.reg_write), .waddr(fin.reg_index),
      .wdata(fin.reg_value), .re(cmd.latch), .raddr(req_data.instruction[20:16]),
      .rdata(rfb_q));

   assign vs = rf_valid_ff[rs] ? rfa_q : rf_reset_value(rs);
   assign vt = rf_valid_ff[rt] ? rfb_q : rf_reset_value(rt);

   assign daddr = vs + simm;
   assign doff  = daddr - data_base_ff;
   assign dok   = (doff < DATA_BYTES);

   assign dram_we    = cmd.clear_step || (cmd.exec && is_store && dok);
   assign dram_waddr = cmd.clear_step ? clr_ff : doff[DADDR_W+1:2];
   assign dram_wdata = cmd.clear_step ? 32'd0 : vt;

   msic_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dram (
      .clock(clock), .we(dram_we), .waddr(dram_waddr), .wdata(dram_wdata),
      .re(cmd.exec && is_load), .raddr(doff[DADDR_W+1:2]), .rdata(dram_q));

   // signed 32x32 product, operands sign-extended by the 64-bit context
   assign prod_in = $signed(vs) * $signed(vt);

   // execute-stage decode
   always_comb begin
      res_in   = '0;
      wr       = 1'b0;
      dest     = ZERO_REG_IDX;
      val      = 32'd0;
      is_mult  = 1'b0;
      is_div   = 1'b0;
      is_load  = 1'b0;
      is_store = 1'b0;
      res_in.next_pc = pc4;
      if (stopped_ff) begin
         res_in.next_pc = pc_ff;
         res_in.halted  = 1'b1;
      end else begin
         case (op)
            OP_SPECIAL: begin
               case (fn)
                  FN_SLL:  begin wr = 1'b1; dest = rd; val = vt << sh; end
                  FN_SRA:  begin wr = 1'b1; dest = rd; val = $signed(vt) >>> sh; end
                  FN_JR:   res_in.next_pc = vs;
                  FN_MFHI: begin wr = 1'b1; dest = rd; val = hi_ff; end
                  FN_MFLO: begin wr = 1'b1; dest = rd; val = lo_ff; end
                  FN_MULT: is_mult = 1'b1;
                  FN_DIV:  is_div = 1'b1;
                  FN_ADDU: begin wr = 1'b1; dest = rd; val = vs + vt; end
                  FN_SUBU: begin wr = 1'b1; dest = rd; val = vs - vt; end
                  FN_SLT:  begin
                     wr = 1'b1; dest = rd;
                     val = {31'd0, $signed(vs) < $signed(vt)};
                  end
                  default: res_in.error_code = ERR_INSN;
               endcase
            end
            OP_J:   res_in.next_pc = {pc4[31:28], ins_ff[25:0], 2'b00};
            OP_JAL: begin
               wr = 1'b1; dest = REG_RA; val = pc4;
               res_in.next_pc = {pc4[31:28], ins_ff[25:0], 2'b00};
            end
            OP_BEQ: if (vs == vt) res_in.next_pc = pc4 + {simm[29:0], 2'b00};
            OP_BNE: if (vs != vt) res_in.next_pc = pc4 + {simm[29:0], 2'b00};
            OP_ADDIU: begin wr = 1'b1; dest = rt; val = vs + simm; end
            OP_ANDI:  begin wr = 1'b1; dest = rt; val = vs & uimm; end
            OP_LUI:   begin wr = 1'b1; dest = rt; val = {ins_ff[15:0], 16'd0}; end
            OP_TRAP: begin
               case (ins_ff[3:0])
                  TRAP_NEWLINE: res_in.print_kind = PK_NEWLINE;
                  TRAP_PRINT: begin
                     res_in.print_kind  = PK_INT;
                     res_in.print_value = vs;
                  end
                  TRAP_READ: begin
                     res_in.print_kind = PK_PROMPT;
                     wr = 1'b1; dest = rt; val = cval_ff;
                  end
                  TRAP_HALT: res_in.halted = 1'b1;
                  default: begin
                     res_in.halted     = 1'b1;
                     res_in.error_code = ERR_TRAP;
                  end
               endcase
            end
            OP_LW: begin
               is_load = 1'b1;
               if (dok) begin wr = 1'b1; dest = rt; end
               else res_in.error_code = ERR_DADDR;
            end
            OP_SW: begin
               is_store = 1'b1;
               if (!dok) res_in.error_code = ERR_DADDR;
            end
            default: res_in.error_code = ERR_INSN;
         endcase
      end
      if (wr && dest != ZERO_REG_IDX) begin
         res_in.reg_write = 1'b1;
         res_in.reg_index = dest;
         res_in.reg_value = val;
      end
   end

   // divider step: restoring, one quotient bit per cycle
   assign dtmp = {rem_ff, quo_ff[31]};
   assign dge  = (dtmp >= {1'b0, mb_ff});

   // final result, load data merged in
   always_comb begin
      fin = res_ff;
      if (load_ff && res_ff.reg_write) fin.reg_value = dram_q;
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         ins_ff  <= req_data.instruction;
         cval_ff <= req_data.console_value;
      end
      if (cmd.exec) begin
         res_ff  <= res_in;
         load_ff <= is_load && dok;
         prod_ff <= prod_in;
         quo_ff  <= vs[31] ? (32'd0 - vs) : vs;
         mb_ff   <= vt[31] ? (32'd0 - vt) : vt;
         rem_ff  <= 32'd0;
         dcnt_ff <= 5'd0;
         qneg_ff <= vs[31] ^ vt[31];
         rneg_ff <= vs[31];
      end
      if (cmd.div_step) begin
         rem_ff  <= dge ? 32'(dtmp - {1'b0, mb_ff}) : dtmp[31:0];
         quo_ff  <= {quo_ff[30:0], dge};
         dcnt_ff <= dcnt_ff + 5'd1;
      end
      if (cmd.commit) rsp_ff <= fin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= START_PC_RESET;
         hi_ff        <= 32'd0;
         lo_ff        <= 32'd0;
         stopped_ff   <= 1'b0;
         rf_valid_ff  <= 32'd0;
         data_base_ff <= DATA_BASE_RESET;
         clr_ff       <= '0;
         mult_ff      <= 1'b0;
         div_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // start_pc has no effect (the PC reset value is fixed), so its writes are dropped
         if (csr_write && csr_index == CSR_DATA_BASE) data_base_ff <= csr_wdata;
         if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
         if (cmd.exec) begin
            mult_ff <= is_mult;
            div_ff  <= is_div && (vt != 32'd0);
         end
         if (cmd.commit) begin
            pc_ff      <= fin.next_pc;
            stopped_ff <= fin.halted;
            if (fin.reg_write) rf_valid_ff[fin.reg_index] <= 1'b1;
            if (mult_ff) begin
               hi_ff <= prod_ff[63:32];
               lo_ff <= prod_ff[31:0];
            end
            if (div_ff) begin
               lo_ff <= qneg_ff ? (32'd0 - quo_ff) : quo_ff;
               hi_ff <= rneg_ff ? (32'd0 - rem_ff) : rem_ff;
            end
            mult_ff <= 1'b0;
            div_ff  <= 1'b0;
         end
         if (cmd.commit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign sts.clear_last = (clr_ff == DADDR_W'(DATA_WORDS - 1));
   assign sts.div_go     = is_div && (vt != 32'd0);
   assign sts.div_last   = (dcnt_ff == 5'd31);
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `MSIC_ASSERT_NOW(a_commit_slot_free, clock, reset,
      cmd.commit, !rsp_valid_ff || rsp_ready)
   `MSIC_ASSERT_NOW(a_no_zero_write, clock, reset,
      cmd.commit && fin.reg_write, fin.reg_index != ZERO_REG_IDX)
endmodule

>>> dv/tb_mips_subset_instruction_core.sv
// Testbench for the MIPS integer subset instruction core.
module tb_mips_subset_instruction_core;
   timeunit 1ns;
   timeprecision 1ps;
   import msic_pkg::*;

   // Predicts every response of the core from the requests it accepted.
   // It keeps its own copy of the architectural state and the csr values.
   class instruction_predictor;
      logic [31:0] start_pc;
      logic [31:0] data_base;
      logic [31:0] pc;
      logic [31:0] hi;
      logic [31:0] lo;
      logic [31:0] regs [32];
      logic [31:0] dmem [DATA_WORDS];
      bit          stopped;
      rsp_type     pending_results[$];
      int          mismatches;
      int          checked;

      function new();
         start_pc  = START_PC_RESET;
         data_base = DATA_BASE_RESET;
         pc        = START_PC_RESET;
         hi        = '0;
         lo        = '0;
         stopped   = 0;
         foreach (regs[i]) regs[i] = '0;
         regs[REG_GP] = GP_RESET;
         regs[REG_SP] = SP_RESET;
         foreach (dmem[i]) dmem[i] = '0;
         mismatches = 0;
         checked    = 0;
      endfunction

      // start_pc has no effect on the core, so a write just gets recorded
      function void set_csr(logic idx, logic [31:0] value);
         if (idx == CSR_START_PC) start_pc = value;
         else data_base = value;
      endfunction

      function void accept_instruction(req_type r);
         logic [31:0] ins, vs, vt, simm, uimm, nxt, val, off, ma, mb, q, rm, pv;
         logic [5:0]  op, fn;
         logic [4:0]  rs, rt, rd, sh, dest;
         logic [63:0] prod;
         logic [1:0]  err, pk;
         bit          wr;
         rsp_type     e;
         e = '0;
         if (stopped) begin
            e.next_pc = pc;
            e.halted  = 1'b1;
            pending_results.push_back(e);
            return;
         end
         ins  = r.instruction;
         op   = ins[31:26];
         rs   = ins[25:21];
         rt   = ins[20:16];
         rd   = ins[15:11];
         sh   = ins[10:6];
         fn   = ins[5:0];
         uimm = {16'd0, ins[15:0]};
         simm = {{16{ins[15]}}, ins[15:0]};
         vs   = regs[rs];
         vt   = regs[rt];
         nxt  = pc + 32'd4;
         wr   = 0;
         dest = '0;
         val  = '0;
         err  = ERR_NONE;
         pk   = PK_NONE;
         pv   = '0;
         case (op)
            OP_SPECIAL: begin
               case (fn)
                  FN_SLL:  begin wr = 1; dest = rd; val = vt << sh; end
                  FN_SRA:  begin wr = 1; dest = rd; val = $signed(vt) >>> sh; end
                  FN_JR:   nxt = vs;
                  FN_MFHI: begin wr = 1; dest = rd; val = hi; end
                  FN_MFLO: begin wr = 1; dest = rd; val = lo; end
                  FN_MULT: begin
                     prod = {{32{vs[31]}}, vs} * {{32{vt[31]}}, vt};
                     hi = prod[63:32];
                     lo = prod[31:0];
                  end
                  FN_DIV: begin
                     // divide by zero leaves hi/lo alone
                     if (vt != 0) begin
                        ma = vs[31] ? -vs : vs;
                        mb = vt[31] ? -vt : vt;
                        q  = ma / mb;
                        rm = ma % mb;
                        if (vs[31] ^ vt[31]) q = -q;
                        if (vs[31]) rm = -rm;
                        lo = q;
                        hi = rm;
                     end
                  end
                  FN_ADDU: begin wr = 1; dest = rd; val = vs + vt; end
                  FN_SUBU: begin wr = 1; dest = rd; val = vs - vt; end
                  FN_SLT:  begin wr = 1; dest = rd; val = ($signed(vs) < $signed(vt)) ? 1 : 0; end
                  default: err = ERR_INSN;
               endcase
            end
            OP_J:   nxt = {nxt[31:28], ins[25:0], 2'b00};
            OP_JAL: begin
               wr = 1; dest = REG_RA; val = nxt;
               nxt = {nxt[31:28], ins[25:0], 2'b00};
            end
            OP_BEQ:   if (vs == vt) nxt = nxt + (simm << 2);
            OP_BNE:   if (vs != vt) nxt = nxt + (simm << 2);
            OP_ADDIU: begin wr = 1; dest = rt; val = vs + simm; end
            OP_ANDI:  begin wr = 1; dest = rt; val = vs & uimm; end
            OP_LUI:   begin wr = 1; dest = rt; val = uimm << 16; end
            OP_TRAP: begin
               case (ins[3:0])
                  TRAP_NEWLINE: pk = PK_NEWLINE;
                  TRAP_PRINT:   begin pk = PK_INT; pv = vs; end
                  TRAP_READ:    begin pk = PK_PROMPT; wr = 1; dest = rt; val = r.console_value; end
                  TRAP_HALT:    stopped = 1;
                  default:      begin stopped = 1; err = ERR_TRAP; end
               endcase
            end
            OP_LW, OP_SW: begin
               off = vs + simm - data_base;
               if (off < DATA_BYTES) begin
                  if (op == OP_LW) begin
                     wr = 1; dest = rt; val = dmem[off[DADDR_W+1:2]];
                  end else begin
                     dmem[off[DADDR_W+1:2]] = vt;
                  end
               end else begin
                  err = ERR_DADDR;
               end
            end
            default: err = ERR_INSN;
         endcase
         if (wr && dest != ZERO_REG_IDX) begin
            regs[dest] = val;
         end else begin
            wr = 0; dest = '0; val = '0;
         end
         pc           = nxt;
         e.next_pc    = nxt;
         e.reg_write  = wr;
         e.reg_index  = dest;
         e.reg_value  = val;
         e.halted     = stopped;
         e.error_code = err;
         e.print_kind = pk;
         e.print_value = pv;
         pending_results.push_back(e);
      endfunction

      function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
         if (exp !== act) begin
            $error("%s: expected %h, got %h", name, exp, act);
            mismatches++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding: %h", got);
            mismatches++;
            return;
         end
         e = pending_results.pop_front();
         checked++;
         compare_field("next_pc", e.next_pc, got.next_pc);
         compare_field("reg_write", e.reg_write, got.reg_write);
         compare_field("reg_index", e.reg_index, got.reg_index);
         compare_field("reg_value", e.reg_value, got.reg_value);
         compare_field("halted", e.halted, got.halted);
         compare_field("error_code", e.error_code, got.error_code);
         compare_field("print_kind", e.print_kind, got.print_kind);
         compare_field("print_value", e.print_value, got.print_value);
      endfunction
   endclass

   localparam int ITEMS_PER_PHASE = 410;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int DRAIN_CYCLES    = 40;   // longer than a div

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;
   logic    csr_write = 0;
   logic    csr_index = CSR_START_PC;
   logic [31:0] csr_wdata = '0;

   instruction_predictor sb = new();
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int issued = 0;
   int cycles = 0;

   mips_subset_instruction_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // Watchdog: sized from the slowest legal run with lots of slack.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   // Response side: check on every handshake, then pick next cycle's ready.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic logic [31:0] enc_r(logic [4:0] rs, rt, rd, sh, logic [5:0] fn);
      return {OP_SPECIAL, rs, rt, rd, sh, fn};
   endfunction

   function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, rt, logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [31:0] enc_trap(logic [3:0] sel);
      return {OP_TRAP, 22'($urandom), sel};
   endfunction

   // Random instruction from everything except lw/sw and the stopping traps.
   // div is kept rare since its pass through the divider is slow.
   function automatic logic [31:0] random_instruction();
      logic [31:0] ins;
      logic [5:0]  op, fn;
      logic [3:0]  sel;
      ins = $urandom;
      case ($urandom_range(0, 19))
         0:  ins[31:26] = OP_J;
         1:  ins[31:26] = OP_JAL;
         2:  begin ins[31:26] = OP_BEQ; if ($urandom_range(1)) ins[20:16] = ins[25:21]; end
         3:  ins[31:26] = OP_BNE;
         4:  ins[31:26] = OP_ADDIU;
         5:  ins[31:26] = OP_ANDI;
         6:  ins[31:26] = OP_LUI;
         7:  begin
            case ($urandom_range(2))
               0: sel = TRAP_NEWLINE;
               1: sel = TRAP_PRINT;
               default: sel = TRAP_READ;
            endcase
            ins = enc_trap(sel);
         end
         8: begin
            do op = 6'($urandom);
            while (op inside {OP_SPECIAL, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDIU,
                              OP_ANDI, OP_LUI, OP_TRAP, OP_LW, OP_SW});
            ins[31:26] = op;
         end
         9: begin
            do fn = 6'($urandom);
            while (fn inside {FN_SLL, FN_SRA, FN_JR, FN_MFHI, FN_MFLO, FN_MULT,
                              FN_DIV, FN_ADDU, FN_SUBU, FN_SLT});
            ins[31:26] = OP_SPECIAL;
            ins[5:0]   = fn;
         end
         default: begin
            ins[31:26] = OP_SPECIAL;
            case ($urandom_range(0, 19))
               0, 1:   ins[5:0] = FN_SLL;
               2, 3:   ins[5:0] = FN_SRA;
               4:      ins[5:0] = FN_JR;
               5, 6:   ins[5:0] = FN_MFHI;
               7, 8:   ins[5:0] = FN_MFLO;
               9, 10:  ins[5:0] = FN_MULT;
               11:     ins[5:0] = FN_DIV;
               12, 13: ins[5:0] = FN_ADDU;
               14, 15: ins[5:0] = FN_SUBU;
               default: ins[5:0] = FN_SLT;
            endcase
         end
      endcase
      return ins;
   endfunction

   // Sends one request and waits for its handshake; may then go idle.
   task automatic issue(input logic [31:0] ins);
      req_type r;
      r.instruction   = ins;
      r.console_value = $urandom;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sb.accept_instruction(r);
      issued++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // lui + lw/sw pair aimed at the data window; some land outside it.
   task automatic issue_memory_access();
      logic [31:0] addr;
      logic [15:0] upper;
      logic [4:0]  base;
      addr  = sb.data_base + ($urandom_range(9) == 0 ? $urandom : $urandom_range(0, 4095));
      upper = 16'((addr + 32'h8000) >> 16);
      base  = 5'($urandom_range(1, 31));
      issue(enc_i(OP_LUI, 5'd0, base, upper));
      issue(enc_i($urandom_range(1) ? OP_LW : OP_SW, base, 5'($urandom), addr[15:0]));
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      sb.set_csr(idx, value);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [31:0] bases [4];
      int          target;
      bases = '{DATA_BASE_RESET, 32'h0000_0000, 32'hFFFF_F000, 32'h1001_0000};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // csr writes are taken during the memory clearing pass
      write_csr(CSR_START_PC, 32'hFFFF_FFFF);
      write_csr(CSR_DATA_BASE, bases[0]);

      // Directed: overflow divide, divide by zero, shifts, $zero writes,
      // console traps, window edges, bad opcode/funct, jumps and branches.
      issue(enc_i(OP_LUI, 5'd0, 5'd1, 16'h8000));
      issue(enc_i(OP_ADDIU, 5'd0, 5'd2, 16'hFFFF));
      issue(enc_r(5'd1, 5'd2, 5'd0, 5'd0, FN_DIV));
      issue(enc_r(5'd0, 5'd0, 5'd3, 5'd0, FN_MFHI));
      issue(enc_r(5'd0, 5'd0, 5'd4, 5'd0, FN_MFLO));
      issue(enc_r(5'd1, 5'd0, 5'd0, 5'd0, FN_DIV));
      issue(enc_r(5'd0, 5'd0, 5'd5, 5'd0, FN_MFLO));
      issue(enc_r(5'd1, 5'd1, 5'd0, 5'd0, FN_MULT));
      issue(enc_r(5'd0, 5'd0, 5'd6, 5'd0, FN_MFHI));
      issue(enc_r(5'd0, 5'd2, 5'd7, 5'd31, FN_SLL));
      issue(enc_r(5'd0, 5'd1, 5'd8, 5'd31, FN_SRA));
      issue(enc_r(5'd1, 5'd2, 5'd9, 5'd0, FN_SLT));
      issue(enc_r(5'd0, 5'd2, 5'd10, 5'd0, FN_SUBU));
      issue(enc_i(OP_ANDI, 5'd2, 5'd11, 16'hFFFF));
      issue(enc_r(5'd1, 5'd2, 5'd0, 5'd0, FN_ADDU));
      issue(enc_i(OP_TRAP, 5'd0, 5'd0, {12'd0, TRAP_READ}));
      issue(enc_i(OP_TRAP, 5'd0, 5'd12, {12'd0, TRAP_READ}));
      issue(enc_i(OP_TRAP, 5'd1, 5'd0, {12'd0, TRAP_PRINT}));
      issue(enc_trap(TRAP_NEWLINE));
      issue(enc_i(OP_SW, REG_SP, 5'd2, 16'hFFFC));   // last word of the window
      issue(enc_i(OP_LW, REG_SP, 5'd13, 16'hFFFC));
      issue(enc_i(OP_LW, REG_SP, 5'd14, 16'h0000));  // one past the end
      issue(enc_i(OP_SW, REG_GP, 5'd2, 16'h0000));   // $gp is outside the window
      issue(32'hFFFF_FFFF);
      issue(enc_r(5'd0, 5'd0, 5'd0, 5'd0, 6'h3F));
      issue({OP_JAL, 26'h3FF_FFFF});
      issue(enc_i(OP_BEQ, 5'd0, 5'd0, 16'h8000));
      issue(enc_r(5'd2, 5'd0, 5'd0, 5'd0, FN_JR));

      // Four handshake phases, each with its own data window.
      for (int ph = 0; ph < 4; ph++) begin
         if (ph > 0) begin
            wait_idle();
            write_csr(CSR_DATA_BASE, bases[ph]);
            write_csr(CSR_START_PC, ph[0] ? 32'h0000_0000 : START_PC_RESET);
         end
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 70; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 70; end
            default: begin send_idle_pct = 36; rsp_stall_pct = 36; end
         endcase
         target = issued + ITEMS_PER_PHASE;
         while (issued < target) begin
            if ($urandom_range(3) == 0) issue_memory_access();
            else issue(random_instruction());
         end
      end

      // Stop the machine last: bad trap selector, then everything is ignored.
      issue(enc_trap(4'hF));
      issue(enc_trap(TRAP_HALT));
      repeat (3) issue(random_instruction());

      wait_idle();
      $display("%0d instructions sent over four handshake phases and four data windows,",
               issued);
      $display("%0d responses checked, ending in the stopped state", sb.checked);
      if (sb.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
